@@ src/ordered_list_keyed_deque_core_defines.svh @@
// Assertion helpers shared by the core.
`ifndef ORDERED_LIST_KEYED_DEQUE_CORE_DEFINES_SVH
`define ORDERED_LIST_KEYED_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define OLKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define OLKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/olkd_pkg.sv @@
package olkd_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int COUNT_W    = 5;
  localparam int PRICE_W    = 8;
  localparam logic [PRICE_W-1:0] PRICE_RESET = 8'd8;

  // operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REMOVE_KEY = 3'd4;
  localparam logic [2:0] OP_FIND_KEY   = 3'd5;
  localparam logic [2:0] OP_IS_EMPTY   = 3'd6;
  localparam logic [2:0] OP_CLEAR      = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [63:0] client_tag;
    logic [15:0] quantity;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        found_client;
    logic [15:0]        found_quantity;
    logic [23:0]        found_total;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } out_res_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] client;
    logic [15:0] quantity;
    logic [23:0] total;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

endpackage

@@ src/ordered_list_keyed_deque_core.sv @@
// Bounded ordered list of keyed entries, used as a deque with keyed find
// and remove. Entries sit compacted in a single-port-write RAM, slot 0 at
// the front; a small sequencer walks that RAM through one key comparator.
//
// Request channel: drive in_req and raise start; the request is taken on
// a clock edge where start is high and busy is low. busy stays high while
// a request is being worked on.
// Result channel: out_valid pulses for one cycle with out_res. Every
// request gives exactly one result. The receiver cannot stall it.
// Config: cfg_wr_en/cfg_wr_data write unit_price; write only while idle.
//
// is_empty, clear, pop_back, full or empty outcomes and pop_front of one
// entry need no walk; busy stays low. push_back writes its slot; push_front
// moves all entries up a slot, back to front, then writes slot 0; pop_front
// moves entries down a slot; find_key and remove_key read from the front
// to a match or the last slot, and remove_key moves later entries down.
// busy is low again in the result cycle, so the next request can be taken
// at the edge ending it. Walks read one slot and move one slot per cycle.
// Reset (rst_n low, synchronous) empties the list and sets unit_price to 8;
// the RAM contents are not cleared, as slots are only read below the count.
`include "ordered_list_keyed_deque_core_defines.svh"

module ordered_list_keyed_deque_core
  import olkd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_req_t            in_req,
  output logic               out_valid,
  output out_res_t           out_res,
  input  logic               cfg_wr_en,
  input  logic [PRICE_W-1:0] cfg_wr_data
);

  logic [PRICE_W-1:0] price_r;
  ram_ctl_t           ram_ctl;
  entry_t             rdata;

  // unit price register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_r <= PRICE_RESET;
    end else if (cfg_wr_en) begin
      price_r <= cfg_wr_data;
    end
  end

  // entry store: key, client tag, quantity, total per slot
  olkd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata),
    .raddr (ram_ctl.raddr),
    .rdata (rdata)
  );

  // sequencer: search, compaction and insert walks
  olkd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (in_req),
    .price     (price_r),
    .rdata     (rdata),
    .ram_ctl   (ram_ctl),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // a taken request either finishes next cycle or keeps the core busy
  `OLKD_ASSERT_NEXT(a_req_progress, clk, rst_n, start && !busy,
                    out_valid || busy, "request lost")
  // results only appear once the walk is over
  `OLKD_ASSERT_NOW(a_res_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // empty flag agrees with the reported count
  `OLKD_ASSERT_NOW(a_empty_flag, clk, rst_n, out_valid && (out_res.entry_count != '0),
                   !out_res.is_empty, "empty flag with entries")

endmodule

@@ src/olkd_ram.sv @@
module olkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/olkd_unit.sv @@
module olkd_unit
  import olkd_pkg::*;
(
  input  logic [31:0]        key_a,
  input  logic [31:0]        key_b,
  input  logic [15:0]        quantity,
  input  logic [PRICE_W-1:0] price,
  output logic               match,
  output logic [23:0]        total
);

  // shared key comparator, plus the price product for pushes
  assign match = (key_a == key_b);
  assign total = 24'(quantity * price);

endmodule

@@ src/olkd_seq.sv @@
module olkd_seq
  import olkd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_req_t            req,
  input  logic [PRICE_W-1:0] price,
  input  entry_t             rdata,
  output ram_ctl_t           ram_ctl,
  output logic               out_valid,
  output out_res_t           out_res
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_SHIFT_DN = 3'd2;
  localparam logic [2:0] S_SHIFT_UP = 3'd3;
  localparam logic [2:0] S_WRITE    = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  in_req_t          req_r, req_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_res_r, out_res_nxt;

  logic             key_match;
  logic [23:0]      total;
  logic             done;
  logic [1:0]       status;
  logic             hit;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] ptr_inc;
  logic             full;
  logic             empty;

  olkd_unit u_unit (
    .key_a    (rdata.key),
    .key_b    (req_r.key),
    .quantity (req_r.quantity),
    .price    (price),
    .match    (key_match),
    .total    (total)
  );

  assign last    = IDX_W'(occ_r - CNT_W'(1));
  assign ptr_inc = IDX_W'(ptr_r + IDX_W'(1));
  assign full    = (occ_r == CNT_W'(LIST_DEPTH));
  assign empty   = (occ_r == '0);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    occ_nxt       = occ_r;
    req_nxt       = req_r;
    done          = 1'b0;
    status        = ST_OK;
    hit           = 1'b0;
    ram_ctl.we    = 1'b0;
    ram_ctl.waddr = ptr_r;
    ram_ctl.wdata = rdata;
    ram_ctl.raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req;
          unique case (req.op) inside
            OP_PUSH_FRONT: begin
              if (full) begin
                done   = 1'b1;
                status = ST_FULL;
              end else if (empty) begin
                ptr_nxt   = '0;
                state_nxt = S_WRITE;
              end else begin
                // open slot 0 by moving everything up, back to front
                ram_ctl.raddr = last;
                ptr_nxt       = last;
                state_nxt     = S_SHIFT_UP;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                done   = 1'b1;
                status = ST_FULL;
              end else begin
                ptr_nxt   = IDX_W'(occ_r);
                state_nxt = S_WRITE;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                done   = 1'b1;
                status = ST_EMPTY;
              end else if (occ_r == CNT_W'(1)) begin
                occ_nxt = '0;
                done    = 1'b1;
              end else begin
                ram_ctl.raddr = IDX_W'(1);
                ptr_nxt       = '0;
                state_nxt     = S_SHIFT_DN;
              end
            end
            OP_POP_BACK: begin
              done = 1'b1;
              if (empty) begin
                status = ST_EMPTY;
              end else begin
                occ_nxt = occ_r - CNT_W'(1);
              end
            end
            OP_REMOVE_KEY, OP_FIND_KEY: begin
              if (empty) begin
                done   = 1'b1;
                status = (req.op == OP_FIND_KEY) ? ST_NOTFOUND : ST_EMPTY;
              end else begin
                ram_ctl.raddr = '0;
                ptr_nxt       = '0;
                state_nxt     = S_SEARCH;
              end
            end
            OP_IS_EMPTY: begin
              done = 1'b1;
            end
            OP_CLEAR: begin
              occ_nxt = '0;
              done    = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // rdata holds slot ptr_r; fetch the next one ahead
        ram_ctl.raddr = ptr_inc;
        if (key_match) begin
          if (req_r.op == OP_FIND_KEY) begin
            hit  = 1'b1;
            done = 1'b1;
          end else if (ptr_r == last) begin
            occ_nxt = occ_r - CNT_W'(1);
            done    = 1'b1;
          end else begin
            state_nxt = S_SHIFT_DN;
          end
        end else if (ptr_r == last) begin
          status = ST_NOTFOUND;
          done   = 1'b1;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      S_SHIFT_DN: begin
        // rdata holds slot ptr_r+1, moves down into ptr_r
        ram_ctl.we    = 1'b1;
        ram_ctl.waddr = ptr_r;
        ram_ctl.raddr = IDX_W'(ptr_r + IDX_W'(2));
        if (ptr_inc == last) begin
          occ_nxt = occ_r - CNT_W'(1);
          done    = 1'b1;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      S_SHIFT_UP: begin
        // rdata holds slot ptr_r, moves up into ptr_r+1
        ram_ctl.we    = 1'b1;
        ram_ctl.waddr = ptr_inc;
        if (ptr_r == '0) begin
          state_nxt = S_WRITE;
        end else begin
          ram_ctl.raddr = IDX_W'(ptr_r - IDX_W'(1));
          ptr_nxt       = IDX_W'(ptr_r - IDX_W'(1));
        end
      end

      S_WRITE: begin
        ram_ctl.we             = 1'b1;
        ram_ctl.waddr          = ptr_r;
        ram_ctl.wdata.key      = req_r.key;
        ram_ctl.wdata.client   = req_r.client_tag;
        ram_ctl.wdata.quantity = req_r.quantity;
        ram_ctl.wdata.total    = total;
        occ_nxt                = occ_r + CNT_W'(1);
        done                   = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = S_IDLE;
    end

    out_valid_nxt              = done;
    out_res_nxt.status         = status;
    out_res_nxt.found_client   = hit ? rdata.client : '0;
    out_res_nxt.found_quantity = hit ? rdata.quantity : '0;
    out_res_nxt.found_total    = hit ? rdata.total : '0;
    out_res_nxt.entry_count    = COUNT_W'(occ_nxt);
    out_res_nxt.is_empty       = (occ_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    req_r <= req_nxt;
    if (out_valid_nxt) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ verif/tb_ordered_list_keyed_deque_core.sv @@
`timescale 1ns / 100ps

// Every request gives one result. The shadow list below is updated at the
// edge where the request is taken, and the expected result is queued. The DUT
// never holds results off, so only the request side idles.
module tb_ordered_list_keyed_deque_core;
  import olkd_pkg::*;

  localparam int SETTLE_CYCLES = 4;   // quiet cycles before a price write
  localparam int TAIL_CYCLES   = 40;  // outlasts the slowest request walk
  localparam int PHASE_REQS    = 200;

  typedef enum logic [1:0] {
    ITEM_REQ,      // one request to the list
    ITEM_PRICE,    // unit_price write, always queued after a quiesce
    ITEM_QUIESCE,  // hold off until every result is back
    ITEM_PACE      // change the idle rate on the request side
  } item_kind_t;

  typedef struct {
    item_kind_t         kind;
    in_req_t            req;
    logic [PRICE_W-1:0] price;
    int                 idle_pct;
  } stim_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_wr_en = 1'b0;
  logic [PRICE_W-1:0] cfg_wr_data = '0;

  stim_item_t req_backlog[$];
  out_res_t   expected_results[$];
  logic       req_taken = 1'b0;
  int         fail_count = 0;

  // Shadow of the list: slot 0 is the front, slots below list_count are live.
  entry_t             list_slots[LIST_DEPTH];
  int                 list_count;
  logic [PRICE_W-1:0] list_price;

  ordered_list_keyed_deque_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // First slot holding the key, or list_count when there is none.
  function automatic int key_slot(logic [31:0] key);
    int i;
    for (i = 0; i < list_count; i++)
      if (list_slots[i].key == key) return i;
    return list_count;
  endfunction

  // Drop one slot and close the gap toward the front.
  function automatic void close_slot(int idx);
    int i;
    for (i = idx; i + 1 < list_count; i++) list_slots[i] = list_slots[i + 1];
    list_count--;
  endfunction

  // Apply one request to the shadow list; returns the result it must give.
  function automatic out_res_t list_apply(in_req_t r);
    out_res_t res;
    int idx;
    int i;
    logic [23:0] total;
    res = '0;
    res.status = ST_OK;
    total = 24'(r.quantity) * 24'(list_price);
    case (r.op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          idx = list_count;
          if (r.op == OP_PUSH_FRONT) begin
            for (i = list_count; i > 0; i--) list_slots[i] = list_slots[i - 1];
            idx = 0;
          end
          list_slots[idx].key = r.key;
          list_slots[idx].client = r.client_tag;
          list_slots[idx].quantity = r.quantity;
          list_slots[idx].total = total;
          list_count++;
        end
      end
      OP_POP_FRONT: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else close_slot(0);
      end
      OP_POP_BACK: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else list_count--;
      end
      OP_REMOVE_KEY: begin
        idx = key_slot(r.key);
        if (list_count == 0) res.status = ST_EMPTY;
        else if (idx < list_count) close_slot(idx);
        else res.status = ST_NOTFOUND;
      end
      OP_FIND_KEY: begin
        idx = key_slot(r.key);
        if (idx < list_count) begin
          res.found_client = list_slots[idx].client;
          res.found_quantity = list_slots[idx].quantity;
          res.found_total = list_slots[idx].total;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      OP_IS_EMPTY: ;
      default: list_count = 0;  // clear
    endcase
    res.entry_count = COUNT_W'(list_count);
    res.is_empty = (list_count == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: takes requests and price writes into the shadow list, and
  // checks every result strobe against the oldest expectation.
  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      req_taken <= 1'b0;
      list_count = 0;
      list_price = PRICE_RESET;
      expected_results.delete();
    end else begin
      req_taken <= start && !busy;
      if (cfg_wr_en) list_price = cfg_wr_data;
      if (start && !busy) expected_results.push_back(list_apply(in_req));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_res.status);
          check_field("found_client", want.found_client, out_res.found_client);
          check_field("found_quantity", want.found_quantity, out_res.found_quantity);
          check_field("found_total", want.found_total, out_res.found_total);
          check_field("entry_count", want.entry_count, out_res.entry_count);
          check_field("is_empty", want.is_empty, out_res.is_empty);
        end
      end
    end
  end

  // Driver: works off the backlog at the falling edge. A raised start is
  // held with the same request until the monitor saw it taken.
  int idle_pct = 0;
  int hold_cycles = 0;

  always @(negedge clk) begin
    logic nxt_start;
    logic nxt_cfg;
    stim_item_t item;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else if (!(start && !req_taken)) begin
      nxt_start = 1'b0;
      nxt_cfg = 1'b0;
      if (hold_cycles != 0) begin
        hold_cycles--;
      end else if (req_backlog.size() != 0) begin
        item = req_backlog[0];
        case (item.kind)
          ITEM_REQ: begin
            if ($urandom_range(99) >= idle_pct) begin
              nxt_start = 1'b1;
              in_req <= item.req;
              void'(req_backlog.pop_front());
            end
          end
          ITEM_PRICE: begin
            nxt_cfg = 1'b1;
            cfg_wr_data <= item.price;
            void'(req_backlog.pop_front());
          end
          ITEM_QUIESCE: begin
            // all results back and nothing in flight: let it settle
            if (expected_results.size() == 0 && !busy) begin
              hold_cycles = SETTLE_CYCLES;
              void'(req_backlog.pop_front());
            end
          end
          default: begin
            idle_pct = item.idle_pct;
            void'(req_backlog.pop_front());
          end
        endcase
      end
      start <= nxt_start;
      cfg_wr_en <= nxt_cfg;
    end
  end

  // Stimulus and end of run.
  logic [31:0] key_pool[6];

  task automatic queue_req(logic [2:0] op, logic [31:0] key, logic [63:0] client,
                           logic [15:0] qty);
    stim_item_t item;
    item.kind = ITEM_REQ;
    item.req.op = op;
    item.req.key = key;
    item.req.client_tag = client;
    item.req.quantity = qty;
    req_backlog.push_back(item);
  endtask

  task automatic queue_ctl(item_kind_t kind, logic [PRICE_W-1:0] price, int pct);
    stim_item_t item;
    item.kind = kind;
    item.req = '0;
    item.price = price;
    item.idle_pct = pct;
    req_backlog.push_back(item);
  endtask

  // Fill mode leans on pushes to reach a full list; drain mode on pops.
  function automatic logic [2:0] pick_op(bit filling);
    int roll;
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 28) return OP_PUSH_FRONT;
      if (roll < 56) return OP_PUSH_BACK;
      if (roll < 70) return OP_FIND_KEY;
      if (roll < 80) return OP_REMOVE_KEY;
      if (roll < 86) return OP_POP_FRONT;
      if (roll < 92) return OP_POP_BACK;
      if (roll < 98) return OP_IS_EMPTY;
      return OP_CLEAR;
    end
    if (roll < 10) return OP_PUSH_FRONT;
    if (roll < 20) return OP_PUSH_BACK;
    if (roll < 40) return OP_POP_FRONT;
    if (roll < 60) return OP_POP_BACK;
    if (roll < 78) return OP_REMOVE_KEY;
    if (roll < 92) return OP_FIND_KEY;
    if (roll < 97) return OP_IS_EMPTY;
    return OP_CLEAR;
  endfunction

  // Mostly keys from a small pool so finds and removes hit.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  initial begin
    logic [PRICE_W-1:0] phase_price[5];
    int phase_idle[5];
    int p;
    int n;
    int run_left;
    bit filling;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (n = 2; n < 6; n++) key_pool[n] = $urandom;

    // Directed: every op on an empty list, field extremes, duplicate keys,
    // push onto a full list, then empty it again.
    queue_req(OP_IS_EMPTY, '0, '0, '0);
    queue_req(OP_POP_FRONT, '0, '0, '0);
    queue_req(OP_POP_BACK, '0, '0, '0);
    queue_req(OP_REMOVE_KEY, '1, '0, '0);
    queue_req(OP_FIND_KEY, '0, '0, '0);
    queue_req(OP_CLEAR, '0, '0, '0);
    queue_req(OP_PUSH_BACK, '1, '1, '1);
    queue_req(OP_PUSH_FRONT, '0, '0, '0);
    queue_req(OP_FIND_KEY, '1, '0, '0);
    queue_req(OP_FIND_KEY, 32'h0000_1234, '0, '0);
    queue_req(OP_REMOVE_KEY, 32'h0000_1234, '0, '0);
    for (n = 0; n < LIST_DEPTH - 2; n++)
      queue_req(n[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'(n % 3),
                {$urandom, $urandom}, 16'($urandom));
    queue_req(OP_PUSH_BACK, 32'd7, '1, '1);
    queue_req(OP_PUSH_FRONT, 32'd7, '1, '1);
    queue_req(OP_FIND_KEY, 32'd1, '0, '0);
    queue_req(OP_REMOVE_KEY, 32'd1, '0, '0);
    queue_req(OP_POP_FRONT, '0, '0, '0);
    queue_req(OP_POP_BACK, '0, '0, '0);
    queue_req(OP_CLEAR, '0, '0, '0);
    queue_req(OP_IS_EMPTY, '0, '0, '0);

    // Random phases: each one waits for the list to go quiet, sets a new
    // price (extremes included) and idle rate. The third phase would be
    // the receiver-stall one, which has no meaning on this port.
    phase_price = '{8'd255, 8'd0, 8'd1, 8'($urandom), PRICE_RESET};
    phase_idle = '{0, 58, 0, 16, $urandom_range(0, 70)};
    for (p = 0; p < 5; p++) begin
      queue_ctl(ITEM_QUIESCE, '0, 0);
      queue_ctl(ITEM_PRICE, phase_price[p], 0);
      queue_ctl(ITEM_PACE, '0, phase_idle[p]);
      // largest total the price allows
      queue_req(OP_PUSH_BACK, key_pool[p], {$urandom, $urandom}, '1);
      queue_req(OP_FIND_KEY, key_pool[p], '0, '0);
      filling = 1'b1;
      run_left = $urandom_range(15, 40);
      for (n = 0; n < PHASE_REQS; n++) begin
        if (run_left == 0) begin
          filling = !filling;
          run_left = $urandom_range(15, 40);
        end
        run_left--;
        queue_req(pick_op(filling), pick_key(), {$urandom, $urandom}, 16'($urandom));
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (req_backlog.size() != 0 || start || expected_results.size() != 0);
    // catch any stray strobe after the last expected result
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: fails the run if it hangs.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
